// File: rtl/uer_pkg.sv
// Shared widths and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int CAPTURE_BITS = 16;
  localparam int ECHO_W       = 16;
  localparam int DIST_W       = 16;
  localparam int Q4_BITS      = 4;
  localparam int RATE_W       = 12;

  // Serial divider: dividend is the echo width scaled by 16, divisor the Q8.4 rate.
  localparam int DIV_DVD_W    = ECHO_W + Q4_BITS;
  localparam int DIV_DSR_W    = RATE_W;
  localparam int DIV_CNT_W    = $clog2(DIV_DVD_W);

  localparam logic [DIST_W-1:0] SAT16 = {DIST_W{1'b1}};

  typedef logic [DIV_DVD_W-1:0] div_dvd_t;
  typedef logic [DIV_DSR_W-1:0] div_dsr_t;
  typedef logic [DIST_W-1:0]    dist_t;

endpackage

// File: rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: edge machine, tick sequencer, median filter.
//
// Input channel (in_valid / in_stall) takes one event per transfer: a control
// tick (in_req_type 0) or an echo capture (in_req_type 1) with the timer value
// and pin level. Every event gives exactly one result on the output channel
// (out_valid / out_stall), held in an output register.
// A capture event goes from transfer straight to S_OUT. A tick passes through
// S_POST, and through S_DIV and S_STORE before it when a measured echo waits
// for conversion: the centimetre conversion runs through a bit-serial divider
// at one quotient bit per cycle over 20 bits. One event is in work at a time;
// in_stall is high while it is. The next event is taken while a result still
// sits in the output register; it waits there only if that register is still full.
// The configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
// always ready; writes belong between events.
// Synchronous active-low reset loads the register defaults, idles the edge
// machine, marks the reading stale and empties the output register.
// While the receiver stalls, the result holds steady on the output ports.
module ultrasonic_echo_ranger (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [uer_pkg::CAPTURE_BITS-1:0]  in_capture_value,
  input  logic                              in_echo_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_fire_trigger,
  output logic [uer_pkg::DIST_W-1:0]        out_distance_cm,
  output logic                              out_reading_valid,
  output logic                              out_obstacle_ahead,
  output logic [uer_pkg::ECHO_W-1:0]        out_last_echo_us,
  output logic [31:0]                       out_echo_total,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);
  import uer_pkg::*;

  localparam logic [2:0] CFG_US_PER_CM = 3'd0;
  localparam logic [2:0] CFG_MIN_RANGE = 3'd1;
  localparam logic [2:0] CFG_MAX_RANGE = 3'd2;
  localparam logic [2:0] CFG_TIMEOUT   = 3'd3;
  localparam logic [2:0] CFG_STALE     = 3'd4;
  localparam logic [2:0] CFG_PERIOD    = 3'd5;
  localparam logic [2:0] CFG_STOP      = 3'd6;

  localparam logic [1:0] MED_LAST = 2'd2;
  localparam logic [1:0] MED_FULL = 2'd3;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_STORE, S_POST, S_OUT} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_RISE, PH_WAIT_FALL} phase_t;

  function automatic dist_t med3(input dist_t a, input dist_t b, input dist_t c);
    dist_t lo, hi, mid;
    lo  = (a > b) ? b : a;
    hi  = (a > b) ? a : b;
    mid = (hi > c) ? c : hi;
    mid = (lo > mid) ? lo : mid;
    return mid;
  endfunction

  // configuration
  logic [RATE_W-1:0] rate_r;
  dist_t             min_r, max_r, stop_r;
  logic [15:0]       timeout_r, stale_r, period_r;

  // sequencer and ranging state
  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [CAPTURE_BITS-1:0] rise_r, rise_nxt;
  logic [ECHO_W-1:0]       width_r, width_nxt;
  logic [31:0]             count_r, count_nxt;
  logic                    pend_r, pend_nxt;
  dist_t                   med_r [3];
  dist_t                   med_nxt [3];
  logic [1:0]              store_idx_r, store_idx_nxt;
  logic [1:0]              store_fill_r, store_fill_nxt;
  dist_t                   held_r, held_nxt;
  logic                    present_r, present_nxt;
  logic [15:0]             tst_r, tst_nxt;
  logic [15:0]             tsr_r, tsr_nxt;
  logic                    fire_r, fire_nxt;
  dist_t                   cm_r, cm_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    o_fire_r, o_valid_rd_r, o_obst_r;
  dist_t                   o_dist_r;
  logic [ECHO_W-1:0]       o_echo_r;
  logic [31:0]             o_total_r;
  logic                    out_load;

  logic                    in_xfer;
  logic                    div_start, div_done;
  dist_t                   div_q;
  logic [CAPTURE_BITS-1:0] cap_diff;
  dist_t                   cand [3];
  logic [1:0]              fill_inc;
  phase_t                  phase_to;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign div_start = in_xfer && !in_req_type && pend_r;
  assign cap_diff  = in_capture_value - rise_r;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  uer_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({width_r, {Q4_BITS{1'b0}}}),
    .divisor  (rate_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // median candidates with the new sample in its slot
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i] = (store_idx_r == 2'(i)) ? cm_r : med_r[i];
    end
  end

  assign fill_inc = (store_fill_r == MED_FULL) ? store_fill_r : store_fill_r + 2'd1;
  assign phase_to = (phase_r != PH_IDLE && tst_r >= timeout_r) ? PH_IDLE : phase_r;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    rise_nxt       = rise_r;
    width_nxt      = width_r;
    count_nxt      = count_r;
    pend_nxt       = pend_r;
    med_nxt        = med_r;
    store_idx_nxt  = store_idx_r;
    store_fill_nxt = store_fill_r;
    held_nxt       = held_r;
    present_nxt    = present_r;
    tst_nxt        = tst_r;
    tsr_nxt        = tsr_r;
    fire_nxt       = fire_r;
    cm_nxt         = cm_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          fire_nxt = 1'b0;
          if (!in_req_type) begin
            if (tst_r != 16'hFFFF) tst_nxt = tst_r + 16'd1;
            if (tsr_r != 16'hFFFF) tsr_nxt = tsr_r + 16'd1;
            if (pend_r) begin
              pend_nxt  = 1'b0;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_POST;
            end
          end else begin
            if (in_echo_level) begin
              if (phase_r == PH_WAIT_RISE) begin
                rise_nxt  = in_capture_value;
                phase_nxt = PH_WAIT_FALL;
              end
            end else if (phase_r == PH_WAIT_FALL) begin
              width_nxt = ECHO_W'(cap_diff);
              pend_nxt  = 1'b1;
              count_nxt = count_r + 32'd1;
              phase_nxt = PH_IDLE;
            end
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          cm_nxt    = div_q;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        if (cm_r >= min_r && cm_r <= max_r) begin
          med_nxt[store_idx_r] = cm_r;
          store_idx_nxt  = (store_idx_r == MED_LAST) ? 2'd0 : store_idx_r + 2'd1;
          store_fill_nxt = fill_inc;
          held_nxt       = (fill_inc == MED_FULL) ? med3(cand[0], cand[1], cand[2]) : cm_r;
          present_nxt    = 1'b1;
          tsr_nxt        = '0;
        end
        state_nxt = S_POST;
      end
      S_POST: begin
        phase_nxt = phase_to;
        if (tsr_r >= stale_r) begin
          present_nxt    = 1'b0;
          held_nxt       = '0;
          store_fill_nxt = '0;
          store_idx_nxt  = '0;
        end
        if (phase_to == PH_IDLE && tst_r >= period_r) begin
          tst_nxt   = '0;
          phase_nxt = PH_WAIT_RISE;
          fire_nxt  = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    med_r <= med_nxt;
    cm_r  <= cm_nxt;
    if (out_load) begin
      o_fire_r     <= fire_r;
      o_dist_r     <= present_r ? held_r : '0;
      o_valid_rd_r <= present_r;
      o_obst_r     <= !present_r || (held_r <= stop_r);
      o_echo_r     <= width_r;
      o_total_r    <= count_r;
    end
    if (!rst_n) begin
      rate_r       <= RATE_W'(928);
      min_r        <= 16'd2;
      max_r        <= 16'd400;
      timeout_r    <= 16'd3;
      stale_r      <= 16'd50;
      period_r     <= 16'd6;
      stop_r       <= 16'd20;
      state_r      <= S_IDLE;
      phase_r      <= PH_IDLE;
      rise_r       <= '0;
      width_r      <= '0;
      count_r      <= '0;
      pend_r       <= 1'b0;
      store_idx_r  <= '0;
      store_fill_r <= '0;
      held_r       <= '0;
      present_r    <= 1'b0;
      tst_r        <= '0;
      tsr_r        <= 16'hFFFF;
      fire_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      rise_r       <= rise_nxt;
      width_r      <= width_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      store_idx_r  <= store_idx_nxt;
      store_fill_r <= store_fill_nxt;
      held_r       <= held_nxt;
      present_r    <= present_nxt;
      tst_r        <= tst_nxt;
      tsr_r        <= tsr_nxt;
      fire_r       <= fire_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_US_PER_CM: rate_r    <= cfg_data[RATE_W-1:0];
          CFG_MIN_RANGE: min_r     <= cfg_data;
          CFG_MAX_RANGE: max_r     <= cfg_data;
          CFG_TIMEOUT:   timeout_r <= cfg_data;
          CFG_STALE:     stale_r   <= cfg_data;
          CFG_PERIOD:    period_r  <= cfg_data;
          CFG_STOP:      stop_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fire_trigger   = o_fire_r;
  assign out_distance_cm    = o_dist_r;
  assign out_reading_valid  = o_valid_rd_r;
  assign out_obstacle_ahead = o_obst_r;
  assign out_last_echo_us   = o_echo_r;
  assign out_echo_total     = o_total_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    store_idx_r != MED_FULL)
    else $error("median store index out of range");

  a_no_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reading_valid) |-> (out_distance_cm == '0 && out_obstacle_ahead))
    else $error("no-reading result carries a distance or clears obstacle");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the conversion state");

  a_fire_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST && fire_nxt) |=> (tst_r == '0 && phase_r == PH_WAIT_RISE))
    else $error("ping request did not restart trigger timing");
`endif

endmodule

// File: rtl/uer_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, saturating 16-bit quotient.
module uer_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  uer_pkg::div_dvd_t dividend,
  input  uer_pkg::div_dsr_t divisor,
  output logic            done,
  output uer_pkg::dist_t  quotient
);
  import uer_pkg::*;

  logic [DIV_DSR_W-1:0] rem_r, rem_nxt;
  logic [DIV_DVD_W-1:0] shq_r, shq_nxt;
  logic [DIV_DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DSR_W:0]   trial;
  logic [DIV_DSR_W:0]   diff;
  logic                 ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, shq_r[DIV_DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    rem_nxt  = rem_r;
    shq_nxt  = shq_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      shq_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIV_DVD_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
      shq_nxt = {shq_r[DIV_DVD_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    shq_r <= shq_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // A zero divisor yields all ones, which saturates as required.
  assign done     = done_r;
  assign quotient = (|shq_r[DIV_DVD_W-1:DIST_W]) ? SAT16 : shq_r[DIST_W-1:0];

endmodule
